// ===== rtl/core/ilir_pkg.sv =====
// Package for the indexed list insert/remove unit.
// Holds the transaction structs, action and status codes and the cell control bundle.
// No dependencies.
`default_nettype none

package ilir_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int IDX_W         = 5;
    localparam int VAL_W         = 32;
    localparam int CNT_OUT_W     = 5;

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value_bits;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        t_status              status;
        logic [CNT_OUT_W-1:0] item_count;
    } t_out_item;

    // Broadcast to every cell; the op bits are already qualified by the range checks.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              set;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/ilir_cell.sv =====
// One storage cell of the list: holds the entry at position POS.
// Depends on ilir_pkg (t_cell_ctrl, VAL_W).
`default_nettype none

module ilir_cell #(
    parameter int POS = 0
) (
    input  wire                          i_clk,
    input  ilir_pkg::t_cell_ctrl         i_ctrl,
    input  wire [ilir_pkg::VAL_W-1:0]    i_left,   // entry of cell POS-1
    input  wire [ilir_pkg::VAL_W-1:0]    i_right,  // entry of cell POS+1
    output logic [ilir_pkg::VAL_W-1:0]   o_q
);

    logic [ilir_pkg::VAL_W-1:0] r_q;
    logic [ilir_pkg::VAL_W-1:0] n_q;
    logic                       w_hit;
    logic                       w_above;

    assign w_hit   = (POS == int'(i_ctrl.idx));
    assign w_above = (POS >  int'(i_ctrl.idx));

    always_comb begin
        n_q = r_q;
        if (i_ctrl.ins) begin
            if (w_above) begin
                n_q = i_left;
            end else if (w_hit) begin
                n_q = i_ctrl.value;
            end
        end
        // entries past the count pick up don't-care data, never read
        if (i_ctrl.rem && (w_above || w_hit)) begin
            n_q = i_right;
        end
        if (i_ctrl.set && w_hit) begin
            n_q = i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_insert_remove_unit.sv =====
// Top level of the indexed list insert/remove unit: a row of storage cells plus control.
// Depends on ilir_pkg and ilir_cell.
`default_nettype none

// Usage
//   Fixed-capacity ordered list of 32-bit entries, DEPTH entries deep.
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low. i_cmd carries action (get, set, insert, remove), index and value_bits.
//   busy is always low: every cycle can carry a new command.
//   Result channel: o_done pulses for one cycle, in the cycle after the
//   command edge, with o_rsp = {read_value, status, item_count}. The receiver
//   cannot stall; the result is gone after that cycle.
//   Throughput 1 transaction per cycle. That figure is set by the
//   cell row: each cell loads from its left or right neighbor in the same edge, so
//   an insert or remove moves the whole tail of the list at once; get is one
//   DEPTH:1 select over the cell outputs.
//   Reset (synchronous, active low) clears the count and the result strobe. Cell
//   contents are not reset; entries are only read below the count, and every one
//   of those has been written.
//   item_count reports the count after the command, kept to its 5 bits.

module indexed_list_insert_remove_unit #(
    parameter int DEPTH = ilir_pkg::DEPTH_DEFAULT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  ilir_pkg::t_in_item    i_cmd,
    output logic                  o_done,
    output ilir_pkg::t_out_item   o_rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ilir_pkg::IDX_W) ? CW : ilir_pkg::IDX_W;

    // ---------------- control state
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_done;
    ilir_pkg::t_out_item     r_rsp;
    ilir_pkg::t_out_item     n_rsp;

    logic                    w_accept;
    logic [CMPW-1:0]         w_idx;
    logic [CMPW-1:0]         w_cnt;
    logic [CMPW-1:0]         w_cnt_next;
    logic                    w_in_rng;     // index < count
    logic                    w_ins_rng;    // index <= count
    logic                    w_full;
    logic [ilir_pkg::VAL_W-1:0] w_rd;
    ilir_pkg::t_cell_ctrl    w_ctrl;

    logic [ilir_pkg::VAL_W-1:0] w_q     [DEPTH];
    logic [ilir_pkg::VAL_W-1:0] w_left  [DEPTH];
    logic [ilir_pkg::VAL_W-1:0] w_right [DEPTH];

    assign busy     = 1'b0;           // one command per cycle, never held off
    assign w_accept = start && !busy;

    assign w_idx     = CMPW'(i_cmd.index);
    assign w_cnt     = CMPW'(r_count);
    assign w_in_rng  = (w_idx <  w_cnt);
    assign w_ins_rng = (w_idx <= w_cnt);
    assign w_full    = (r_count == CW'(DEPTH));

    // get: select the addressed cell (only indices below the count are used)
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (k == int'(i_cmd.index)) begin
                w_rd = w_q[k];
            end
        end
    end

    // decode the command into cell controls, next count and result
    always_comb begin
        w_ctrl       = '0;
        w_ctrl.idx   = i_cmd.index;
        w_ctrl.value = i_cmd.value_bits;
        n_count      = r_count;
        n_rsp.read_value = '0;
        n_rsp.status     = ilir_pkg::ST_OK;
        if (w_accept) begin
            case (i_cmd.action)
                ilir_pkg::ACT_GET: begin
                    if (w_in_rng) begin
                        n_rsp.read_value = w_rd;
                    end else begin
                        n_rsp.status = ilir_pkg::ST_RANGE;
                    end
                end
                ilir_pkg::ACT_SET: begin
                    if (w_in_rng) begin
                        w_ctrl.set = 1'b1;
                    end else begin
                        n_rsp.status = ilir_pkg::ST_RANGE;
                    end
                end
                ilir_pkg::ACT_INSERT: begin
                    // range check wins over the full check
                    if (!w_ins_rng) begin
                        n_rsp.status = ilir_pkg::ST_RANGE;
                    end else if (w_full) begin
                        n_rsp.status = ilir_pkg::ST_FULL;
                    end else begin
                        w_ctrl.ins = 1'b1;
                        n_count    = r_count + CW'(1);
                    end
                end
                ilir_pkg::ACT_REMOVE: begin
                    if (w_in_rng) begin
                        w_ctrl.rem = 1'b1;
                        n_count    = r_count - CW'(1);
                    end else begin
                        n_rsp.status = ilir_pkg::ST_RANGE;
                    end
                end
                default: begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end
            endcase
        end
        w_cnt_next       = CMPW'(n_count);
        n_rsp.item_count = w_cnt_next[ilir_pkg::CNT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // ---------------- cell row; each cell sees its two neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_left[k] = i_cmd.value_bits;
        end else begin : g_mid_l
            assign w_left[k] = w_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right[k] = '0;
        end else begin : g_mid_r
            assign w_right[k] = w_q[k+1];
        end

        ilir_cell #(
            .POS (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .o_q     (w_q[k])
        );
    end

`ifndef SYNTHESIS
    // every accepted command yields exactly one result strobe, in the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("result strobe missing after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done)
        else $error("result strobe without transaction");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above capacity");

    // a failed command leaves the list length unchanged and reads zero
    a_err_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ilir_pkg::ST_OK)) |->
            ((r_count == $past(r_count)) && (o_rsp.read_value == '0)))
        else $error("error result changed count or returned data");
`endif

endmodule

`default_nettype wire
